>>> src/basic_program_detokenizer_defines.svh
// Assertion macros used by the top-level detokenizer file.
`ifndef BASIC_PROGRAM_DETOKENIZER_DEFINES_SVH
`define BASIC_PROGRAM_DETOKENIZER_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define BPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define BPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bpd_pkg.sv
package bpd_pkg;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Commands from the front to the back
    localparam logic [2:0] OP_CHAR   = 3'd0;
    localparam logic [2:0] OP_KW     = 3'd1;
    localparam logic [2:0] OP_NUM    = 3'd2;
    localparam logic [2:0] OP_ERR    = 3'd3;
    localparam logic [2:0] OP_END    = 3'd4;
    localparam logic [2:0] OP_NL_END = 3'd5;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] NEWLINE     = 8'd10;
    localparam logic [7:0] SPACE       = 8'd32;
    localparam logic [7:0] DIGIT_ZERO  = 8'd48;
    localparam logic [7:0] FIRST_NO_KW = 8'd252;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] kind;
        logic       last;
    } out_item_t;

    // word: char in [7:0], line number in [15:0], or keyword right-justified
    // cnt: index of the first character to send, counting down to zero
    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] word;
        logic [2:0]  cnt;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    typedef struct packed {
        logic avail;
        cmd_t cmd;
    } q_rd_t;

    // k times the decimal weight of a digit place; place 5 is ten thousands
    function automatic logic [16:0] dec_mult(input logic [2:0] place, input logic [3:0] k);
        logic [16:0] p;
        case (place)
            3'd5:    p = 17'd10000;
            3'd4:    p = 17'd1000;
            3'd3:    p = 17'd100;
            3'd2:    p = 17'd10;
            3'd1:    p = 17'd1;
            default: p = 17'd0;
        endcase
        return 17'({13'd0, k} * p);
    endfunction

    // Keyword text, right-justified, zero bytes above the first character
    function automatic logic [63:0] kw_word(input logic [6:0] idx);
        logic [63:0] w;
        case (idx)
            7'd0:   w = 64'("END ");
            7'd1:   w = 64'("FOR ");
            7'd2:   w = 64'("RESET");
            7'd3:   w = 64'("SET");
            7'd4:   w = 64'("CLS ");
            7'd5:   w = 64'("CMD ");
            7'd6:   w = 64'("RANDOM ");
            7'd7:   w = 64'("NEXT ");
            7'd8:   w = 64'("DATA ");
            7'd9:   w = 64'("INPUT ");
            7'd10:  w = 64'("DIM ");
            7'd11:  w = 64'("READ ");
            7'd12:  w = 64'("LET ");
            7'd13:  w = 64'(" GOTO ");
            7'd14:  w = 64'("RUN ");
            7'd15:  w = 64'("IF ");
            7'd16:  w = 64'("RESTORE ");
            7'd17:  w = 64'(" GOSUB ");
            7'd18:  w = 64'("RETURN ");
            7'd19:  w = 64'("REM ");
            7'd20:  w = 64'("STOP ");
            7'd21:  w = 64'(" ELSE ");
            7'd22:  w = 64'("TRON ");
            7'd23:  w = 64'("TROFF ");
            7'd24:  w = 64'("DEFSTR ");
            7'd25:  w = 64'("DEFINT ");
            7'd26:  w = 64'("DEFSNG ");
            7'd27:  w = 64'("DEFDBL ");
            7'd28:  w = 64'("LINE ");
            7'd29:  w = 64'("EDIT ");
            7'd30:  w = 64'("ERROR ");
            7'd31:  w = 64'("RESUME ");
            7'd32:  w = 64'("OUT ");
            7'd33:  w = 64'("ON ");
            7'd34:  w = 64'("OPEN ");
            7'd35:  w = 64'("FIELD ");
            7'd36:  w = 64'("GET ");
            7'd37:  w = 64'("PUT ");
            7'd38:  w = 64'("CLOSE ");
            7'd39:  w = 64'("LOAD ");
            7'd40:  w = 64'("MERGE ");
            7'd41:  w = 64'("NAME ");
            7'd42:  w = 64'("KILL ");
            7'd43:  w = 64'("LSET ");
            7'd44:  w = 64'("RSET ");
            7'd45:  w = 64'("SAVE ");
            7'd46:  w = 64'("SYSTEM ");
            7'd47:  w = 64'("LPRINT ");
            7'd48:  w = 64'("DEF ");
            7'd49:  w = 64'("POKE ");
            7'd50:  w = 64'("PRINT ");
            7'd51:  w = 64'("CONT ");
            7'd52:  w = 64'("LIST ");
            7'd53:  w = 64'("LLIST ");
            7'd54:  w = 64'("DELETE ");
            7'd55:  w = 64'("AUTO ");
            7'd56:  w = 64'("CLEAR ");
            7'd57:  w = 64'("CLOAD ");
            7'd58:  w = 64'("CSAVE ");
            7'd59:  w = 64'("NEW ");
            7'd60:  w = 64'("TAB(");
            7'd61:  w = 64'(" TO ");
            7'd62:  w = 64'("FN ");
            7'd63:  w = 64'("USING ");
            7'd64:  w = 64'("VARPTR ");
            7'd65:  w = 64'("USR ");
            7'd66:  w = 64'("ERL ");
            7'd67:  w = 64'("ERR ");
            7'd68:  w = 64'(" STRING$");
            7'd69:  w = 64'(" INSTR");
            7'd70:  w = 64'(" POINT");
            7'd71:  w = 64'(" TIME$ ");
            7'd72:  w = 64'(" MEM ");
            7'd73:  w = 64'(" INKEY$ ");
            7'd74:  w = 64'(" THEN ");
            7'd75:  w = 64'(" NOT ");
            7'd76:  w = 64'(" STEP ");
            7'd77:  w = 64'("+");
            7'd78:  w = 64'("-");
            7'd79:  w = 64'("*");
            7'd80:  w = 64'("/");
            7'd81:  w = 64'("~");
            7'd82:  w = 64'(" AND ");
            7'd83:  w = 64'(" OR ");
            7'd84:  w = 64'(">");
            7'd85:  w = 64'("=");
            7'd86:  w = 64'("<");
            7'd87:  w = 64'(" SGN");
            7'd88:  w = 64'(" INT");
            7'd89:  w = 64'(" ABS");
            7'd90:  w = 64'(" FRE");
            7'd91:  w = 64'(" INP");
            7'd92:  w = 64'(" POS");
            7'd93:  w = 64'(" SQR");
            7'd94:  w = 64'(" RND");
            7'd95:  w = 64'(" LOG");
            7'd96:  w = 64'(" EXP");
            7'd97:  w = 64'(" COS");
            7'd98:  w = 64'(" SIN");
            7'd99:  w = 64'(" TAN");
            7'd100: w = 64'(" ATN");
            7'd101: w = 64'(" PEEK");
            7'd102: w = 64'(" CVI");
            7'd103: w = 64'(" CVS");
            7'd104: w = 64'(" CVD");
            7'd105: w = 64'(" EOF");
            7'd106: w = 64'(" LOC");
            7'd107: w = 64'(" LOF");
            7'd108: w = 64'(" MKI$");
            7'd109: w = 64'(" MKS$");
            7'd110: w = 64'(" MKD$");
            7'd111: w = 64'(" CINT");
            7'd112: w = 64'(" CSNG");
            7'd113: w = 64'(" CDBL");
            7'd114: w = 64'(" FIX");
            7'd115: w = 64'(" LEN");
            7'd116: w = 64'(" STR$");
            7'd117: w = 64'(" VAL");
            7'd118: w = 64'(" ASC");
            7'd119: w = 64'(" CHR$");
            7'd120: w = 64'(" LEFT$");
            7'd121: w = 64'(" RIGHT$");
            7'd122: w = 64'(" MID$");
            7'd123: w = 64'(" ' ");
            default: w = 64'd0;
        endcase
        return w;
    endfunction

endpackage

>>> src/bpd_stream_if.sv
interface bpd_stream_if #(
    parameter type item_t = logic
) ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/bpd_front.sv
module bpd_front (
    input  logic            clk,
    input  logic            rst_n,
    bpd_stream_if.sink      tokens,
    input  logic            q_full,
    output bpd_pkg::q_wr_t  q_wr
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LINK_LO = 3'd1;
    localparam logic [2:0] PH_LINK_HI = 3'd2;
    localparam logic [2:0] PH_NUM_LO  = 3'd3;
    localparam logic [2:0] PH_NUM_HI  = 3'd4;
    localparam logic [2:0] PH_BODY    = 3'd5;
    localparam logic [2:0] PH_STOP    = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic        accept;
    logic [7:0]  b;
    logic [63:0] kw;
    logic [3:0]  kw_len;

    assign tokens.ready = !q_full;
    assign accept       = tokens.valid && tokens.ready;
    assign b            = tokens.data.data_byte;
    assign kw           = bpd_pkg::kw_word(b[6:0]);

    always_comb
    begin
        kw_len = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (kw[i*8 +: 8] != 8'd0)
                kw_len = kw_len + 4'd1;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        q_wr.push   = 1'b0;
        q_wr.cmd.op = bpd_pkg::OP_CHAR;
        q_wr.cmd.word = {56'd0, b};
        q_wr.cmd.cnt  = 3'd0;
        if (accept && phase_reg < PH_STOP)
        begin
            if (tokens.data.end_of_data)
            begin
                q_wr.push   = 1'b1;
                q_wr.cmd.op = (phase_reg == PH_BODY) ? bpd_pkg::OP_NL_END : bpd_pkg::OP_END;
                q_wr.cmd.cnt = 3'd1;
                phase_next  = PH_STOP;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (b != bpd_pkg::HEADER_BYTE)
                        begin
                            q_wr.push   = 1'b1;
                            q_wr.cmd.op = bpd_pkg::OP_ERR;
                            phase_next  = PH_STOP;
                        end
                        else
                            phase_next = PH_LINK_LO;
                    end
                    PH_LINK_LO:
                    begin
                        held_next  = b;
                        phase_next = PH_LINK_HI;
                    end
                    PH_LINK_HI:
                    begin
                        // both link bytes zero: end of program
                        if (held_reg == 8'd0 && b == 8'd0)
                        begin
                            q_wr.push   = 1'b1;
                            q_wr.cmd.op = bpd_pkg::OP_END;
                            phase_next  = PH_STOP;
                        end
                        else
                            phase_next = PH_NUM_LO;
                    end
                    PH_NUM_LO:
                    begin
                        held_next  = b;
                        phase_next = PH_NUM_HI;
                    end
                    PH_NUM_HI:
                    begin
                        q_wr.push     = 1'b1;
                        q_wr.cmd.op   = bpd_pkg::OP_NUM;
                        q_wr.cmd.word = {48'd0, b, held_reg};
                        phase_next    = PH_BODY;
                    end
                    PH_BODY:
                    begin
                        if (b == 8'd0)
                        begin
                            q_wr.push     = 1'b1;
                            q_wr.cmd.word = {56'd0, bpd_pkg::NEWLINE};
                            phase_next    = PH_LINK_LO;
                        end
                        else if (!b[7])
                            q_wr.push = 1'b1;
                        else if (b < bpd_pkg::FIRST_NO_KW)
                        begin
                            q_wr.push     = 1'b1;
                            q_wr.cmd.op   = bpd_pkg::OP_KW;
                            q_wr.cmd.word = kw;
                            q_wr.cmd.cnt  = 3'(kw_len - 4'd1);
                        end
                        // tokens with no keyword: drop
                    end
                    default:
                    begin
                        phase_next = PH_STOP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            held_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> src/bpd_queue.sv
module bpd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bpd_pkg::q_wr_t  q_wr,
    output logic            q_full,
    input  logic            q_pop,
    output bpd_pkg::q_rd_t  q_rd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bpd_pkg::cmd_t   mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign q_full     = (count_reg == FULL_CNT);
    assign q_rd.avail = (count_reg != '0);
    assign q_rd.cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = q_wr.push && !q_full;
    assign do_pop     = q_pop && q_rd.avail;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= q_wr.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

>>> src/bpd_back.sv
module bpd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  bpd_pkg::q_rd_t  q_rd,
    output logic            q_pop,
    bpd_stream_if.source    listing
);

    logic                  busy_reg;
    logic [2:0]            op_reg;
    logic [63:0]           word_reg;
    logic [2:0]            rem_reg;
    logic [2:0]            place_reg;
    logic                  started_reg;
    logic                  out_valid_reg;
    bpd_pkg::out_item_t    out_reg;

    logic                  step, done, emit, load;
    bpd_pkg::out_item_t    beat;
    logic [3:0]            digit;
    logic [15:0]           sub;
    logic [16:0]           mult;

    assign step = busy_reg && (!out_valid_reg || listing.ready);
    assign load = q_rd.avail && (!busy_reg || (step && done));
    assign q_pop = load;

    assign listing.valid = out_valid_reg;
    assign listing.data  = out_reg;

    // largest digit whose weighted value fits in the remaining number
    always_comb
    begin
        digit = 4'd0;
        sub   = 16'd0;
        for (int k = 1; k < 10; k++)
        begin
            mult = bpd_pkg::dec_mult(place_reg, 4'(k));
            if (mult <= {1'b0, word_reg[15:0]})
            begin
                digit = 4'(k);
                sub   = mult[15:0];
            end
        end
    end

    always_comb
    begin
        beat.out_char = 8'd0;
        beat.kind     = bpd_pkg::KIND_CHAR;
        beat.last     = 1'b1;
        emit = 1'b1;
        done = 1'b1;
        case (op_reg)
            bpd_pkg::OP_CHAR:
            begin
                beat.out_char = word_reg[7:0];
            end
            bpd_pkg::OP_KW:
            begin
                beat.out_char = word_reg[{rem_reg, 3'b000} +: 8];
                beat.last     = (rem_reg == 3'd0);
                done          = (rem_reg == 3'd0);
            end
            bpd_pkg::OP_NUM:
            begin
                if (place_reg == 3'd0)
                    beat.out_char = bpd_pkg::SPACE;
                else
                begin
                    beat.out_char = bpd_pkg::DIGIT_ZERO + {4'd0, digit};
                    beat.last     = 1'b0;
                    done          = 1'b0;
                    // skip leading zeros, keep the units digit
                    emit = started_reg || (digit != 4'd0) || (place_reg == 3'd1);
                end
            end
            bpd_pkg::OP_ERR:
            begin
                beat.kind = bpd_pkg::KIND_ERROR;
            end
            bpd_pkg::OP_NL_END:
            begin
                if (rem_reg != 3'd0)
                begin
                    beat.out_char = bpd_pkg::NEWLINE;
                    beat.last     = 1'b0;
                    done          = 1'b0;
                end
                else
                    beat.kind = bpd_pkg::KIND_END;
            end
            default:
            begin
                beat.kind = bpd_pkg::KIND_END;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg      <= q_rd.cmd.op;
            word_reg    <= q_rd.cmd.word;
            rem_reg     <= q_rd.cmd.cnt;
            place_reg   <= 3'd5;
            started_reg <= 1'b0;
        end
        else if (step)
        begin
            rem_reg <= rem_reg - 3'd1;
            if (op_reg == bpd_pkg::OP_NUM && place_reg != 3'd0)
            begin
                word_reg[15:0] <= word_reg[15:0] - sub;
                place_reg      <= place_reg - 3'd1;
                started_reg    <= emit;
            end
        end
        if (step && emit)
            out_reg <= beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                busy_reg <= 1'b1;
            else if (step && done)
                busy_reg <= 1'b0;
            if (step && emit)
                out_valid_reg <= 1'b1;
            else if (listing.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> src/basic_program_detokenizer.sv
// channel   | modport | payload                         | beat when
// tokens    | sink    | data_byte, end_of_data          | valid && ready
// listing   | source  | out_char, kind, last            | valid && ready
//
// A token beat is taken every cycle while the command queue (QUEUE_DEPTH) has room.
// The back end sends at most one listing beat per cycle while listing.ready allows it:
// one per keyword character; a line number steps through five digit places and a space.
// Reset is asynchronous and active low; it returns the parser to the header byte.
// A stalled listing holds its output register; the queue fills, then tokens.ready drops.
`include "basic_program_detokenizer_defines.svh"

module basic_program_detokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    bpd_stream_if.sink    tokens,
    bpd_stream_if.source  listing
);

    bpd_pkg::q_wr_t q_wr;
    bpd_pkg::q_rd_t q_rd;
    logic           q_full;
    logic           q_pop;

    bpd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .tokens (tokens),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    bpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rd   (q_rd)
    );

    bpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rd    (q_rd),
        .q_pop   (q_pop),
        .listing (listing)
    );

    `BPD_ASSERT_IMP(a_no_push_when_full, q_wr.push, !q_full, "command pushed into full queue")
    `BPD_ASSERT_IMP(a_no_pop_when_empty, q_pop, q_rd.avail, "command popped from empty queue")
    `BPD_ASSERT_IMP(a_status_beat_form,
        listing.valid && listing.data.kind != bpd_pkg::KIND_CHAR,
        listing.data.last && listing.data.out_char == 8'd0,
        "status beat not final or carries a character")

endmodule
